// ----- sv/mersenne_twister_prng_top_macros.svh -----
// ----------------------------------------------------------------------------
// MT19937 generator assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MERSENNE_TWISTER_PRNG_TOP_MACROS_SVH
`define MERSENNE_TWISTER_PRNG_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define MTP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("mtp: implication check failed");

`define MTP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("mtp: next-cycle check failed");

`define MTP_ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("mtp: forbidden condition seen");

`else

`define MTP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define MTP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`define MTP_ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// ----- sv/mtp_pkg.sv -----
// ----------------------------------------------------------------------------
// MT19937 generator package
// Table geometry, recurrence constants, tempering and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package mtp_pkg;

	localparam int STATE_WORDS   = 624;
	localparam int MIDDLE_OFFSET = 397;
	localparam int IDX_W         = $clog2(STATE_WORDS);

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(STATE_WORDS - 1);
	localparam logic [IDX_W-1:0] MID_FWD  = IDX_W'(MIDDLE_OFFSET);
	localparam logic [IDX_W-1:0] MID_BACK = IDX_W'(STATE_WORDS - MIDDLE_OFFSET);

	localparam logic [31:0] INIT_MULT    = 32'd1812433253;
	localparam logic [31:0] TWIST_MATRIX = 32'h9908_B0DF;
	localparam logic [31:0] TEMPER_B     = 32'h9D2C_5680;
	localparam logic [31:0] TEMPER_C     = 32'hEFC6_0000;

	typedef enum logic [1:0] {
		ST_UNSEEDED,
		ST_SEED,
		ST_RUN
	} mtp_state_t;

	typedef struct packed {
		logic [31:0] random_word;
		logic        valid_res;
	} mtp_result_t;

	function automatic logic [31:0] temper(input logic [31:0] w);
		logic [31:0] y;
		y = w ^ (w >> 11);
		y = y ^ ((y << 7) & TEMPER_B);
		y = y ^ ((y << 15) & TEMPER_C);
		y = y ^ (y >> 18);
		return y;
	endfunction

endpackage

`default_nettype wire

// ----- sv/mtp_draw_if.sv -----
// ----------------------------------------------------------------------------
// Draw request channel
// Valid/ready channel carrying one draw request per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtp_draw_if;
	logic valid;
	logic ready;
	logic draw_request;

	modport source (output valid, output draw_request, input ready);
	modport sink (input valid, input draw_request, output ready);
endinterface

`default_nettype wire

// ----- sv/mtp_word_if.sv -----
// ----------------------------------------------------------------------------
// Random word channel
// Valid/ready channel carrying one tempered word per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mtp_word_if;
	logic        valid;
	logic        ready;
	logic [31:0] random_word;
	logic        valid_res;

	modport source (output valid, output random_word, output valid_res, input ready);
	modport sink (input valid, input random_word, input valid_res, output ready);
endinterface

`default_nettype wire

// ----- sv/mtp_out_fifo.sv -----
// ----------------------------------------------------------------------------
// MT19937 output queue
// Small result queue decoupling the twist stage from a stalling receiver.
// ----------------------------------------------------------------------------
`default_nettype none

module mtp_out_fifo #(
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	input  mtp_pkg::mtp_result_t         push_data,
	output logic [$clog2(DEPTH+1)-1:0]   level,
	mtp_word_if.source                   word
);
	import mtp_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int LVL_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

	mtp_result_t      slot_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [LVL_W-1:0] level_q;
	logic             pop;

	assign pop              = word.valid && word.ready;
	assign word.valid       = (level_q != '0);
	assign word.random_word = slot_q[rd_ptr_q].random_word;
	assign word.valid_res   = slot_q[rd_ptr_q].valid_res;
	assign level            = level_q;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			end
			unique case ({push, pop})
				2'b10: level_q <= level_q + 1'b1;
				2'b01: level_q <= level_q - 1'b1;
				2'b00: level_q <= level_q;
				2'b11: level_q <= level_q;
			endcase
		end
	end

endmodule

`default_nettype wire

// ----- sv/mersenne_twister_prng_top.sv -----
// ----------------------------------------------------------------------------
// MT19937 random word generator
// 624-word state table in a two-read, one-write memory, regenerated in place.
// ----------------------------------------------------------------------------
// Usage:
//   draw (sink): one transaction per request. A request with draw_request low
//     is taken and yields nothing; with draw_request high it yields exactly one
//     transaction on word (source), in request order.
//   seed_we/seed_value: a write stores the seed in table word 0 and then fills
//     words 1..623 with the initialization recurrence, one word per cycle.
//     draw.ready stays low after the write cycle while those words are written.
//   Before the first seed write each request with draw_request high returns
//     random_word 0 with valid_res 0.
//   Pipeline: a taken request is registered in the s1 stage; its result is
//     then written into the output queue, whose head drives word.
//   Throughput: one request per cycle while draw.ready is high. A draw reads
//     words i+1 and i+397 on the two read ports and writes the regenerated
//     word i, taken from the previous draw's read or, after seeding, the seed.
//   Reset: control state clears, the block is unseeded, the table is unknown.
//   Stall: results wait in an OUT_DEPTH-entry queue; draw.ready drops while the
//     queue plus the word in flight already fill it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mersenne_twister_prng_top_macros.svh"

module mersenne_twister_prng_top #(
	parameter int OUT_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        seed_we,
	input  logic [31:0] seed_value,
	mtp_draw_if.sink    draw,
	mtp_word_if.source  word
);
	import mtp_pkg::*;

	localparam int LVL_W = $clog2(OUT_DEPTH + 1);

	logic [31:0]      state_mem [STATE_WORDS];

	mtp_state_t       state_q;
	mtp_state_t       state_d;
	logic             seeding;
	logic [IDX_W-1:0] seed_k_q;
	logic [31:0]      seed_prev_q;
	logic [31:0]      seed_mix;
	logic [31:0]      seed_next;

	logic [IDX_W-1:0] idx_q;
	logic [IDX_W-1:0] nxt_addr;
	logic [IDX_W-1:0] mid_addr;
	logic [31:0]      cache_q;
	logic [31:0]      cur_word;

	logic             acc;
	logic             gen;
	logic             twist_go;

	logic             res_s1_q;
	logic             twist_s1_q;
	logic [IDX_W-1:0] idx_s1;
	logic [31:0]      cur_s1;
	logic [31:0]      nxt_word_s1;
	logic [31:0]      mid_word_s1;

	logic [31:0]      twist_x;
	logic [31:0]      twist_xa;
	logic [31:0]      new_word;
	mtp_result_t      push_data;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [31:0]      mem_wdata;

	logic [LVL_W-1:0] fifo_level;
	logic [LVL_W:0]   occ;

	// next state
	always_comb begin
		state_d = state_q;
		priority if (seed_we) begin
			state_d = ST_SEED;
		end else begin
			unique case (state_q)
				ST_UNSEEDED: state_d = ST_UNSEEDED;
				ST_SEED: begin
					if (seed_k_q == LAST_IDX) begin
						state_d = ST_RUN;
					end
				end
				ST_RUN: state_d = ST_RUN;
				default: state_d = ST_UNSEEDED;
			endcase
		end
	end

	// state outputs
	always_comb begin
		seeding    = (state_q == ST_SEED);
		occ        = {1'b0, fifo_level} + (LVL_W + 1)'(res_s1_q);
		draw.ready = !seeding && (occ < (LVL_W + 1)'(OUT_DEPTH));
	end

	assign acc      = draw.valid && draw.ready;
	assign gen      = acc && draw.draw_request;
	assign twist_go = gen && (state_q == ST_RUN);

	assign seed_mix  = seed_prev_q ^ (seed_prev_q >> 30);
	assign seed_next = INIT_MULT * seed_mix + {{(32 - IDX_W){1'b0}}, seed_k_q};

	assign nxt_addr = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
	assign mid_addr = (idx_q < MID_BACK) ? idx_q + MID_FWD : idx_q - MID_BACK;

	// forward word i from the read still in flight
	assign cur_word = twist_s1_q ? nxt_word_s1 : cache_q;

	assign twist_x  = {cur_s1[31], nxt_word_s1[30:0]};
	assign twist_xa = (twist_x >> 1) ^ (twist_x[0] ? TWIST_MATRIX : 32'h0);
	assign new_word = mid_word_s1 ^ twist_xa;

	assign push_data.random_word = twist_s1_q ? temper(new_word) : 32'h0;
	assign push_data.valid_res   = twist_s1_q;

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = idx_s1;
		mem_wdata = new_word;
		priority if (seed_we) begin
			mem_we    = 1'b1;
			mem_waddr = '0;
			mem_wdata = seed_value;
		end else if (seeding) begin
			mem_we    = 1'b1;
			mem_waddr = seed_k_q;
			mem_wdata = seed_next;
		end else if (twist_s1_q) begin
			mem_we    = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			state_mem[mem_waddr] <= mem_wdata;
		end
		nxt_word_s1 <= state_mem[nxt_addr];
		mid_word_s1 <= state_mem[mid_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_UNSEEDED;
			seed_k_q   <= '0;
			idx_q      <= '0;
			res_s1_q   <= 1'b0;
			twist_s1_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			res_s1_q   <= gen;
			twist_s1_q <= twist_go;
			if (seed_we) begin
				seed_k_q <= IDX_W'(1);
			end else if (seeding) begin
				seed_k_q <= seed_k_q + 1'b1;
			end
			if (seed_we) begin
				idx_q <= '0;
			end else if (twist_go) begin
				idx_q <= nxt_addr;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (seed_we) begin
			seed_prev_q <= seed_value;
		end else if (seeding) begin
			seed_prev_q <= seed_next;
		end
		if (seed_we) begin
			cache_q <= seed_value;
		end else if (twist_s1_q) begin
			cache_q <= nxt_word_s1;
		end
		if (twist_go) begin
			cur_s1 <= cur_word;
			idx_s1 <= idx_q;
		end
	end

	mtp_out_fifo #(
		.DEPTH (OUT_DEPTH)
	) u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_s1_q),
		.push_data (push_data),
		.level     (fifo_level),
		.word      (word)
	);

	`MTP_ASSERT_NEVER(a_seed_blocks_draw, clk, arst_n, seeding && draw.valid && draw.ready)
	`MTP_ASSERT_NEVER(a_rd_wr_clash, clk, arst_n,
		twist_s1_q && twist_go && ((nxt_addr == idx_s1) || (mid_addr == idx_s1)))
	`MTP_ASSERT_NEVER(a_queue_overrun, clk, arst_n, occ > (LVL_W + 1)'(OUT_DEPTH))
	`MTP_ASSERT_NEVER(a_idx_range, clk, arst_n, idx_q > LAST_IDX)
	`MTP_ASSERT_NXT(a_seed_done, clk, arst_n,
		seeding && (seed_k_q == LAST_IDX) && !seed_we, state_q == ST_RUN)

endmodule

`default_nettype wire

// ----- verif/mtp_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MT19937 word predictor and scoreboard
// Keeps its own copy of the 624-word state table, index and seeded flag.
// Each accepted request with draw_request high queues its expected word,
// tempered or 0 if unseeded; each output word is checked against the oldest.
// ----------------------------------------------------------------------------
package mtp_tb_pkg;

	import mtp_pkg::*;

	class mt_word_predictor;
		logic [31:0] table_words [STATE_WORDS];
		int unsigned next_word;
		bit          seeded;
		mtp_result_t pending_words [$];
		int unsigned mismatch_count;

		function new();
			next_word = 0;
			seeded = 1'b0;
			mismatch_count = 0;
		endfunction

		function void reseed(input logic [31:0] seed);
			logic [31:0] prev;
			table_words[0] = seed;
			for (int k = 1; k < STATE_WORDS; k++) begin
				prev = table_words[k-1];
				table_words[k] = INIT_MULT * (prev ^ (prev >> 30)) + 32'(k);
			end
			next_word = STATE_WORDS;
			seeded = 1'b1;
		endfunction

		function void twist_table();
			logic [31:0] x;
			logic [31:0] xa;
			for (int k = 0; k < STATE_WORDS; k++) begin
				x = {table_words[k][31], table_words[(k + 1) % STATE_WORDS][30:0]};
				xa = x >> 1;
				if (x[0]) begin
					xa = xa ^ TWIST_MATRIX;
				end
				table_words[k] = table_words[(k + MIDDLE_OFFSET) % STATE_WORDS] ^ xa;
			end
			next_word = 0;
		endfunction

		function logic [31:0] tempered(input logic [31:0] w);
			logic [31:0] y;
			y = w ^ (w >> 11);
			y = y ^ ((y << 7) & TEMPER_B);
			y = y ^ ((y << 15) & TEMPER_C);
			y = y ^ (y >> 18);
			return y;
		endfunction

		function void note_draw(input logic draw_request);
			mtp_result_t r;
			if (draw_request !== 1'b1) begin
				return;
			end
			if (!seeded) begin
				r.random_word = '0;
				r.valid_res = 1'b0;
			end else begin
				if (next_word >= STATE_WORDS) begin
					twist_table();
				end
				r.random_word = tempered(table_words[next_word]);
				r.valid_res = 1'b1;
				next_word++;
			end
			pending_words.push_back(r);
		endfunction

		function void report(input string what, input logic [31:0] exp_v,
			input logic [31:0] act_v);
			mismatch_count++;
			if (mismatch_count <= 10) begin
				$display("mismatch: %s expected %h got %h", what, exp_v, act_v);
			end
		endfunction

		function void check_word(input logic [31:0] random_word, input logic valid_res);
			mtp_result_t exp_r;
			if (pending_words.size() == 0) begin
				report("unexpected word transaction", '0, random_word);
				return;
			end
			exp_r = pending_words.pop_front();
			if (random_word !== exp_r.random_word) begin
				report("random_word", exp_r.random_word, random_word);
			end
			if (valid_res !== exp_r.valid_res) begin
				report("valid_res", 32'(exp_r.valid_res), 32'(valid_res));
			end
		endfunction
	endclass

endpackage

// ----- verif/tb_mersenne_twister_prng_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MT19937 generator testbench
// Draws words before any seed, then under the extreme seeds, under seed 5489
// long enough to cross table regeneration, and under three random seeds with
// sender gaps, receiver stalls, and both together. Every word is checked
// against a predictor of the generator.
// ----------------------------------------------------------------------------
module tb_mersenne_twister_prng_top;

	import mtp_tb_pkg::*;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        seed_we;
	logic [31:0] seed_value;
	int          stall_pct;

	mt_word_predictor sb;

	mtp_draw_if draw_ch ();
	mtp_word_if word_ch ();

	mersenne_twister_prng_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.seed_we    (seed_we),
		.seed_value (seed_value),
		.draw       (draw_ch),
		.word       (word_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial word_ch.ready = 1'b0;

	always @(posedge clk) begin
		if (arst_n && word_ch.valid && word_ch.ready) begin
			sb.check_word(word_ch.random_word, word_ch.valid_res);
		end
		word_ch.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
	end

	task automatic send_draw(input logic draw_request);
		draw_ch.valid <= 1'b1;
		draw_ch.draw_request <= draw_request;
		do @(posedge clk); while (!draw_ch.ready);
		sb.note_draw(draw_request);
	endtask

	task automatic wait_drained();
		while (sb.pending_words.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_seed(input logic [31:0] seed);
		seed_we <= 1'b1;
		seed_value <= seed;
		@(posedge clk);
		sb.reseed(seed);
		seed_we <= 1'b0;
	endtask

	task automatic run_phase(input logic [31:0] seed, input int draws, input int gap_pct,
		input int recv_stall);
		int   n;
		logic req;
		n = 0;
		stall_pct = recv_stall;
		write_seed(seed);
		while (n < draws) begin
			if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
				draw_ch.valid <= 1'b0;
				@(posedge clk);
			end else begin
				req = ($urandom_range(9) != 0);
				send_draw(req);
				if (req) begin
					n++;
				end
			end
		end
		draw_ch.valid <= 1'b0;
		wait_drained();
	endtask

	initial begin
		#5_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		sb = new();
		arst_n = 1'b0;
		seed_we = 1'b0;
		seed_value = '0;
		stall_pct = 0;
		draw_ch.valid = 1'b0;
		draw_ch.draw_request = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// unseeded draws, with an idle request among them
		send_draw(1'b1);
		send_draw(1'b0);
		send_draw(1'b1);
		send_draw(1'b1);
		draw_ch.valid <= 1'b0;
		wait_drained();

		run_phase(32'h0000_0000, 6, 0, 0);
		run_phase(32'hFFFF_FFFF, 6, 0, 0);
		run_phase(32'd5489, 700, 0, 0);
		run_phase($urandom, 450, 79, 0);
		run_phase($urandom, 450, 0, 79);
		run_phase($urandom, 450, 18, 18);

		if (sb.mismatch_count == 0 && sb.pending_words.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
